// ----- sv/sfta_pkg.sv -----
// Shared types and constants of the strip and fan triangle assembler.
// No dependencies.

package sfta_pkg;

  localparam int MaxPrimVerts  = 1024;
  localparam int CoordFracBits = 16;
  localparam int ScaleShift    = CoordFracBits - 4;

  localparam int CoordW  = 16;
  localparam int TexW    = 13;
  localparam int CountW  = 11;
  localparam int ProdW   = CoordW + TexW;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegTexWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegTexHeight = 1'b1;

  localparam logic [TexW-1:0] TexSizeReset = 13'd256;

  typedef enum logic [1:0] {
    OP_STRIP  = 2'd0,
    OP_FAN    = 2'd1,
    OP_VERTEX = 2'd2
  } op_e;

  typedef struct packed {
    logic [CoordW-1:0] u;
    logic [CoordW-1:0] v;
  } corner_t;

endpackage

// ----- sv/sfta_scale.sv -----
// Texture coordinate scaler: Q0.16 coordinate times skin size into Q12.4, saturating.
// Depends on sfta_pkg.

module sfta_scale (
  input  logic [sfta_pkg::CoordW-1:0] coord_i,
  input  logic [sfta_pkg::TexW-1:0]   size_i,
  output logic [sfta_pkg::CoordW-1:0] texel_o
);
  import sfta_pkg::*;

  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] shifted;

  assign prod    = ProdW'(coord_i) * ProdW'(size_i);
  assign shifted = prod >> ScaleShift;

  // saturate when anything remains above the low 16 bits
  assign texel_o = (|shifted[ProdW-1:CoordW]) ? {CoordW{1'b1}} : shifted[CoordW-1:0];

endmodule

// ----- sv/strip_fan_triangle_assembler.sv -----
// Strip and fan to triangle list assembler, top level.
// Depends on sfta_pkg and sfta_scale.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries headers and vertices:
//   a strip or fan header opens a primitive of prim_count_i vertices (zero
//   ends the list), a vertex item carries s,t in Q0.16. From the third
//   vertex of a primitive on, each vertex yields one triangle on the output
//   channel (out_valid_o / out_ready_i) with three corners in Q12.4 texels.
//   Throughput: one transaction per cycle unless the receiver stalls.
//   A triangle passes from the input register, through scaling and corner
//   selection, into the output register, from which the receiver takes it.
//   The input register drains into the output register in the same cycle
//   the receiver takes the pending triangle, so a full pipeline still moves
//   one transaction per cycle. When the receiver stalls, the pending
//   triangle holds, one more item waits in the input register, and then
//   in_ready_o drops; items that give no triangle keep draining.
//   Reset clears the primitive state and sets both skin sizes to 256.
//   The user must write skin sizes through cfg_we_i / cfg_idx_i / cfg_data_i
//   only while the block is idle; the block itself does not enforce this.

module strip_fan_triangle_assembler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfta_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfta_pkg::TexW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    opcode_i,
  input  logic [sfta_pkg::CountW-1:0]   prim_count_i,
  input  logic [sfta_pkg::CoordW-1:0]   s_coord_i,
  input  logic [sfta_pkg::CoordW-1:0]   t_coord_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sfta_pkg::CoordW-1:0]   corner0_u_o,
  output logic [sfta_pkg::CoordW-1:0]   corner0_v_o,
  output logic [sfta_pkg::CoordW-1:0]   corner1_u_o,
  output logic [sfta_pkg::CoordW-1:0]   corner1_v_o,
  output logic [sfta_pkg::CoordW-1:0]   corner2_u_o,
  output logic [sfta_pkg::CoordW-1:0]   corner2_v_o
);
  import sfta_pkg::*;

  logic [TexW-1:0]   tex_w_q, tex_h_q;

  logic              s1_valid_q;
  logic [1:0]        s1_op_q;
  logic [CountW-1:0] s1_count_q;
  logic [CoordW-1:0] s1_s_q, s1_t_q;

  logic              fan_q, fan_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [1:0]        seen_q, seen_d;
  logic              odd_q, odd_d;
  corner_t           pivot_q, pivot_d;
  corner_t           older_q, older_d;
  corner_t           newer_q, newer_d;

  logic              out_valid_q;
  corner_t           c0_q, c1_q, c2_q, c0_d, c1_d, c2_d;

  logic [CoordW-1:0] cur_u, cur_v;
  corner_t           cur;
  logic              produce;
  logic              out_free;
  logic              advance;
  logic [CountW-1:0] count_clamped;

  sfta_scale u_scale_s (.coord_i(s1_s_q), .size_i(tex_w_q), .texel_o(cur_u));
  sfta_scale u_scale_t (.coord_i(s1_t_q), .size_i(tex_h_q), .texel_o(cur_v));

  assign cur = '{u: cur_u, v: cur_v};

  assign produce    = (s1_op_q == OP_VERTEX) && (rem_q != '0) && seen_q[1];
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && (!produce || out_free);
  assign in_ready_o = !s1_valid_q || advance;

  assign count_clamped = (32'(s1_count_q) > 32'(MaxPrimVerts)) ?
                         CountW'(MaxPrimVerts) : s1_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q <= TexSizeReset;
      tex_h_q <= TexSizeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTexWidth:  tex_w_q <= cfg_data_i;
        RegTexHeight: tex_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_op_q    <= opcode_i;
      s1_count_q <= prim_count_i;
      s1_s_q     <= s_coord_i;
      s1_t_q     <= t_coord_i;
    end
  end

  always_comb begin
    fan_d   = fan_q;
    rem_d   = rem_q;
    seen_d  = seen_q;
    odd_d   = odd_q;
    pivot_d = pivot_q;
    older_d = older_q;
    newer_d = newer_q;
    c0_d    = cur;
    c1_d    = newer_q;
    c2_d    = older_q;
    if (fan_q) begin
      c2_d = pivot_q;
    end else if (!odd_q) begin
      c0_d = older_q;
      c2_d = cur;
    end
    case (s1_op_q)
      OP_STRIP, OP_FAN: begin
        fan_d  = (s1_op_q == OP_FAN);
        rem_d  = count_clamped;
        seen_d = '0;
        odd_d  = 1'b1;
      end
      OP_VERTEX: begin
        if (rem_q != '0) begin
          if (seen_q[1]) begin
            odd_d = !odd_q;
          end else begin
            if (seen_q == 2'd0) begin
              pivot_d = cur;
            end
            seen_d = seen_q + 2'd1;
          end
          older_d = newer_q;
          newer_d = cur;
          rem_d   = rem_q - CountW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_q   <= 1'b0;
      rem_q   <= '0;
      seen_q  <= '0;
      odd_q   <= 1'b1;
      pivot_q <= '0;
      older_q <= '0;
      newer_q <= '0;
    end else if (advance) begin
      fan_q   <= fan_d;
      rem_q   <= rem_d;
      seen_q  <= seen_d;
      odd_q   <= odd_d;
      pivot_q <= pivot_d;
      older_q <= older_d;
      newer_q <= newer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && produce) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      c0_q <= c0_d;
      c1_q <= c1_d;
      c2_q <= c2_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign corner0_u_o = c0_q.u;
  assign corner0_v_o = c0_q.v;
  assign corner1_u_o = c1_q.u;
  assign corner1_v_o = c1_q.v;
  assign corner2_u_o = c2_q.u;
  assign corner2_v_o = c2_q.v;

endmodule
